FILE: design/gcs_pkg.sv
package gcs_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN_RD,
		ST_MEAN_WB,
		ST_MAT_RD,
		ST_MAT_WB,
		ST_ACC_P,
		ST_QUAD,
		ST_EXP_T,
		ST_EXP_F,
		ST_EXP_E,
		ST_W_RD,
		ST_SCORE_HI,
		ST_SCORE_LO,
		ST_CMP,
		ST_DONE
	} gcs_state_t;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic signed [18:0] LOG2E_Q16 = 19'sd94548;

	// 2^(i/16) in Q2.16, 17 entries
	function automatic logic [17:0] pow2_frac(input logic [4:0] i);
		logic [17:0] v;
		case (i)
			5'd0: v = 18'd65536;
			5'd1: v = 18'd68438;
			5'd2: v = 18'd71468;
			5'd3: v = 18'd74632;
			5'd4: v = 18'd77936;
			5'd5: v = 18'd81386;
			5'd6: v = 18'd84990;
			5'd7: v = 18'd88752;
			5'd8: v = 18'd92682;
			5'd9: v = 18'd96785;
			5'd10: v = 18'd101070;
			5'd11: v = 18'd105545;
			5'd12: v = 18'd110218;
			5'd13: v = 18'd115098;
			5'd14: v = 18'd120194;
			5'd15: v = 18'd125515;
			default: v = 18'd131072;
		endcase
		return v;
	endfunction

endpackage

FILE: design/gcs_ram.sv
module gcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/gaussian_class_scorer.sv
// Gaussian maximum-likelihood class scorer.
// Request channel: start with cmd, gate, model_addr, model_word, feature_0..3;
// a request is taken on a clock edge where start is high and busy is low.
// cmd 0 writes model_word into the model store at model_addr (one per class:
// means, row-major inverse covariance, weight). cmd 1 with gate set scores
// every class and keeps the highest score above zero, the earlier on a tie.
// Result: winning_class with done high for exactly one cycle. A write, a
// gated-off sample or a sample with no classes goes straight to the done state.
// A classification walks the classes in turn: mean reads, inverse
// covariance row products, the exponential, the weight and the compare.
// num_classes is to be written through cfg_we/cfg_data only while idle; the
// block itself does not enforce this. It is limited to MAX_CLASSES and to
// the number of whole class blocks in the store.
// Reset clears the held class and num_classes; the model store is not
// cleared and must be loaded before use. The receiver cannot stall: done is
// a one-cycle strobe.
module gaussian_class_scorer #(
	parameter int NUM_DIMS    = 4,
	parameter int MAX_CLASSES = 16,
	parameter int MODEL_WORDS = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_data,
	input  logic               cmd,
	input  logic               gate,
	input  logic [8:0]         model_addr,
	input  logic signed [31:0] model_word,
	input  logic signed [15:0] feature_0,
	input  logic signed [15:0] feature_1,
	input  logic signed [15:0] feature_2,
	input  logic signed [15:0] feature_3,
	output logic [3:0]         winning_class
);

	localparam int STRIDE = NUM_DIMS * NUM_DIMS + NUM_DIMS + 1;
	localparam int AW     = $clog2(MODEL_WORDS);
	localparam int DW     = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
	localparam int FIT    = MODEL_WORDS / STRIDE;
	localparam int CLIM   = (MAX_CLASSES < FIT) ? MAX_CLASSES : FIT;
	localparam int CW     = $clog2(CLIM + 1);
	localparam int NF     = 4;

	gcs_pkg::gcs_state_t state_q, state_d;

	logic [4:0]           num_classes_q;
	logic [3:0]           held_q;
	logic                 done_q;
	logic signed [15:0]   feat_q [NF];
	logic signed [31:0]   c_q [NUM_DIMS];
	logic [CW-1:0]        k_q;
	logic [DW-1:0]        i_q, j_q;
	logic [AW-1:0]        base_q;
	logic signed [63:0]   prod_q;
	logic signed [63:0]   p_q;
	logic signed [63:0]   q_q;
	logic signed [31:0]   e_q;
	logic signed [21:0]   t_q;
	logic [17:0]          f_q;
	logic [43:0]          ev_q;
	logic signed [63:0]   shi_q, slo_q;
	logic signed [63:0]   best_hi_q;
	logic [21:0]          best_lo_q;
	logic [3:0]           win_q;

	// model store
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	logic signed [31:0] word;

	gcs_ram #(.WIDTH(32), .DEPTH(MODEL_WORDS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(model_addr)),
		.wdata (model_word),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign word   = $signed(ram_rdata);
	assign ram_we = start && !busy && cmd == gcs_pkg::CMD_WRITE
		&& 32'(model_addr) < 32'(MODEL_WORDS);

	// effective class count
	logic [CW-1:0] count;
	always_comb begin
		if (32'(num_classes_q) > 32'(CLIM)) count = CW'(CLIM);
		else count = CW'(num_classes_q);
	end

	// read address follows the step being issued
	always_comb begin
		unique case (state_q)
			gcs_pkg::ST_MEAN_RD:
				ram_raddr = base_q + AW'(j_q);
			gcs_pkg::ST_MAT_RD:
				ram_raddr = base_q + AW'(NUM_DIMS) + AW'(32'(i_q) * NUM_DIMS) + AW'(j_q);
			default:
				ram_raddr = base_q + AW'(STRIDE - 1);
		endcase
	end

	// feature selection, zero beyond the four inputs
	logic signed [15:0] f_j;
	always_comb begin
		if (32'(j_q) < NF) f_j = feat_q[2'(j_q)];
		else f_j = '0;
	end

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	logic signed [63:0] c_raw;
	assign c_raw = 64'(f_j) * 64'sd256 - 64'(word);

	// exp table step
	logic [15:0]        t_frac;
	logic [4:0]         t_idx;
	logic [17:0]        t_lo, t_hi;
	logic signed [5:0]  t_n;
	logic signed [6:0]  t_sh;
	assign t_frac = t_q[15:0];
	assign t_idx  = {1'b0, t_frac[15:12]};
	assign t_lo   = gcs_pkg::pow2_frac(t_idx);
	assign t_hi   = gcs_pkg::pow2_frac(t_idx + 5'd1);
	assign t_n    = t_q[21:16];
	assign t_sh   = 7'(t_n) + 7'sd16;

	logic signed [63:0] e_full;
	assign e_full = (-q_q) >>> 1;

	// sequencer next state
	logic last_j, last_i, last_k;
	assign last_j = 32'(j_q) == NUM_DIMS - 1;
	assign last_i = 32'(i_q) == NUM_DIMS - 1;
	assign last_k = 32'(k_q) + 1 >= 32'(count);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gcs_pkg::ST_IDLE:
				if (start) begin
					if (cmd == gcs_pkg::CMD_SAMPLE && gate && count != '0)
						state_d = gcs_pkg::ST_MEAN_RD;
					else
						state_d = gcs_pkg::ST_DONE;
				end
			gcs_pkg::ST_MEAN_RD:  state_d = gcs_pkg::ST_MEAN_WB;
			gcs_pkg::ST_MEAN_WB:
				state_d = last_j ? gcs_pkg::ST_MAT_RD : gcs_pkg::ST_MEAN_RD;
			gcs_pkg::ST_MAT_RD:   state_d = gcs_pkg::ST_MAT_WB;
			gcs_pkg::ST_MAT_WB:   state_d = gcs_pkg::ST_ACC_P;
			gcs_pkg::ST_ACC_P:
				state_d = last_j ? gcs_pkg::ST_QUAD : gcs_pkg::ST_MAT_RD;
			gcs_pkg::ST_QUAD:
				state_d = last_i ? gcs_pkg::ST_EXP_T : gcs_pkg::ST_MAT_RD;
			gcs_pkg::ST_EXP_T:    state_d = gcs_pkg::ST_EXP_F;
			gcs_pkg::ST_EXP_F:    state_d = gcs_pkg::ST_EXP_E;
			gcs_pkg::ST_EXP_E:    state_d = gcs_pkg::ST_W_RD;
			gcs_pkg::ST_W_RD:     state_d = gcs_pkg::ST_SCORE_HI;
			gcs_pkg::ST_SCORE_HI: state_d = gcs_pkg::ST_SCORE_LO;
			gcs_pkg::ST_SCORE_LO: state_d = gcs_pkg::ST_CMP;
			gcs_pkg::ST_CMP:
				state_d = last_k ? gcs_pkg::ST_DONE : gcs_pkg::ST_MEAN_RD;
			gcs_pkg::ST_DONE:     state_d = gcs_pkg::ST_IDLE;
			default:              state_d = gcs_pkg::ST_IDLE;
		endcase
	end

	assign busy          = state_q != gcs_pkg::ST_IDLE;
	assign done          = done_q;
	assign winning_class = held_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= gcs_pkg::ST_IDLE;
			num_classes_q <= '0;
			held_q        <= '0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == gcs_pkg::ST_DONE;
			if (cfg_we) num_classes_q <= cfg_data;
			// gated sample with no classes to score falls back to class 0
			if (state_q == gcs_pkg::ST_IDLE && start && cmd == gcs_pkg::CMD_SAMPLE
				&& gate && count == '0)
				held_q <= '0;
			if (state_q == gcs_pkg::ST_CMP && last_k) begin
				if ({shi_q, 22'(slo_q)} > {best_hi_q, best_lo_q}
					&& (shi_q > best_hi_q
					|| (shi_q == best_hi_q && slo_q[21:0] > best_lo_q)))
					held_q <= 4'(k_q);
				else
					held_q <= win_q;
			end
		end
	end

	// datapath, one multiply per step, two in the score step
	always_ff @(posedge clk) begin
		unique case (state_q)
			gcs_pkg::ST_IDLE: begin
				feat_q[0] <= feature_0;
				feat_q[1] <= feature_1;
				feat_q[2] <= feature_2;
				feat_q[3] <= feature_3;
				k_q       <= '0;
				i_q       <= '0;
				j_q       <= '0;
				base_q    <= '0;
				best_hi_q <= '0;
				best_lo_q <= '0;
				win_q     <= '0;
				q_q       <= '0;
				p_q       <= '0;
			end
			gcs_pkg::ST_MEAN_WB: begin
				c_q[j_q] <= sat32(c_raw);
				j_q      <= last_j ? '0 : j_q + DW'(1);
			end
			gcs_pkg::ST_MAT_WB:
				prod_q <= 64'(c_q[j_q]) * 64'(word);
			gcs_pkg::ST_ACC_P: begin
				p_q <= p_q + (prod_q >>> 16);
				j_q <= last_j ? '0 : j_q + DW'(1);
			end
			gcs_pkg::ST_QUAD: begin
				q_q <= q_q + ((64'(sat32(p_q)) * 64'(c_q[i_q])) >>> 16);
				p_q <= '0;
				i_q <= last_i ? '0 : i_q + DW'(1);
			end
			gcs_pkg::ST_EXP_T: begin
				if (e_full < -64'sd1048576) e_q <= -32'sd1048576;
				else if (e_full > 64'sd524288) e_q <= 32'sd524288;
				else e_q <= e_full[31:0];
			end
			gcs_pkg::ST_EXP_F:
				t_q <= 22'((64'(e_q) * 64'(gcs_pkg::LOG2E_Q16)) >>> 16);
			gcs_pkg::ST_EXP_E: begin
				f_q <= t_lo + 18'(((36'(t_hi - t_lo)) * 36'(t_frac[11:0])) >> 12);
			end
			gcs_pkg::ST_W_RD: begin
				if (t_sh >= 7'sd0) ev_q <= 44'(f_q) << t_sh[5:0];
				else ev_q <= 44'(f_q) >> 6'(-t_sh);
			end
			gcs_pkg::ST_SCORE_HI: begin
				shi_q <= 64'(word) * 64'(ev_q[43:22]);
				slo_q <= 64'(word) * 64'(ev_q[21:0]);
			end
			gcs_pkg::ST_SCORE_LO: begin
				shi_q <= shi_q + (slo_q >>> 22);
			end
			gcs_pkg::ST_CMP: begin
				if (shi_q > best_hi_q
					|| (shi_q == best_hi_q && slo_q[21:0] > best_lo_q)) begin
					best_hi_q <= shi_q;
					best_lo_q <= slo_q[21:0];
					win_q     <= 4'(k_q);
				end
				k_q    <= k_q + CW'(1);
				base_q <= base_q + AW'(STRIDE);
				q_q    <= '0;
			end
			default: ;
		endcase
	end

	// checks
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == gcs_pkg::ST_DONE))
		else $error("done without completion");
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> $stable(winning_class))
		else $error("result changed while idle");

endmodule

FILE: tb/gcs_checker.sv
`timescale 1ns / 1ps

// Watches the request, config and result channels of the class scorer,
// predicts each winning class and compares it with what comes out.
module gcs_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               done,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_data,
	input  logic               cmd,
	input  logic               gate,
	input  logic [8:0]         model_addr,
	input  logic signed [31:0] model_word,
	input  logic signed [15:0] feature_0,
	input  logic signed [15:0] feature_1,
	input  logic signed [15:0] feature_2,
	input  logic signed [15:0] feature_3,
	input  logic [3:0]         winning_class,
	output int                 pending,
	output int                 failures
);

	localparam int DIMS = 4;
	localparam int CLASSES = 16;
	localparam int WORDS = 512;
	localparam int STRIDE = DIMS * DIMS + DIMS + 1;
	localparam longint LOG2E = 94548;
	localparam longint POW2_TAB [17] = '{65536, 68438, 71468, 74632, 77936, 81386,
		84990, 88752, 92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515,
		131072};

	logic [31:0] coeff_mem [WORDS];
	logic [3:0]  held_win;
	logic [4:0]  class_count;
	logic [3:0]  expected_class [$];

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint coeff(input int a);
		return longint'($signed(coeff_mem[a]));
	endfunction

	// exp(e) as 2^t from the interpolated table, 32 fraction bits
	function automatic longint exp_q32(input longint e);
		longint t, n, f, sh;
		int idx, r;
		t = (e * LOG2E) >>> 16;
		n = t >>> 16;
		idx = int'(t[15:12]);
		r = int'(t[11:0]);
		f = POW2_TAB[idx] + (((POW2_TAB[idx + 1] - POW2_TAB[idx]) * r) >>> 12);
		sh = n + 16;
		if (sh >= 0)
			return f << sh;
		return f >> (-sh);
	endfunction

	function automatic logic [3:0] predict_winner(input longint feat [DIMS]);
		int cnt, base;
		longint c [DIMS];
		longint p, q, e, ev, w, hi, lo, s_hi, s_lo, best_hi, best_lo;
		logic [3:0] win;
		cnt = (class_count > CLASSES) ? CLASSES : int'(class_count);
		best_hi = 0;
		best_lo = 0;
		win = 0;
		for (int k = 0; k < cnt; k++) begin
			base = k * STRIDE;
			for (int j = 0; j < DIMS; j++)
				c[j] = sat32(feat[j] * 256 - coeff(base + j));
			q = 0;
			for (int i = 0; i < DIMS; i++) begin
				p = 0;
				for (int j = 0; j < DIMS; j++)
					p += (c[j] * coeff(base + DIMS + i * DIMS + j)) >>> 16;
				p = sat32(p);
				q += (p * c[i]) >>> 16;
			end
			e = (-q) >>> 1;
			if (e < -(64'sd16 << 16))
				e = -(64'sd16 << 16);
			if (e > (64'sd8 << 16))
				e = 64'sd8 << 16;
			ev = exp_q32(e);
			w = coeff(base + STRIDE - 1);
			hi = w * (ev >>> 22);
			lo = w * (ev & 64'h3FFFFF);
			s_hi = hi + (lo >>> 22);
			s_lo = lo & 64'h3FFFFF;
			// strict win, first class keeps a tie
			if (s_hi > best_hi || (s_hi == best_hi && s_lo > best_lo)) begin
				best_hi = s_hi;
				best_lo = s_lo;
				win = k[3:0];
			end
		end
		return win;
	endfunction

	// predict on each accepted request, check each result strobe
	always @(posedge clk or negedge arst_n) begin
		longint feat [DIMS];
		logic [3:0] want;
		if (!arst_n) begin
			held_win <= '0;
			class_count <= '0;
			expected_class.delete();
			pending <= 0;
			failures <= 0;
		end else begin
			if (done) begin
				if (expected_class.size() == 0) begin
					if (failures < 10)
						$display("unexpected result %0d at %0t", winning_class, $realtime);
					failures <= failures + 1;
				end else begin
					want = expected_class.pop_front();
					if (want !== winning_class) begin
						if (failures < 10)
							$display("winning_class mismatch: expected %0d got %0d at %0t",
								want, winning_class, $realtime);
						failures <= failures + 1;
					end
				end
			end
			if (cfg_we)
				class_count <= cfg_data;
			if (start && !busy) begin
				want = held_win;
				if (cmd == gcs_pkg::CMD_WRITE) begin
					coeff_mem[model_addr] = model_word;
				end else if (gate) begin
					feat[0] = feature_0;
					feat[1] = feature_1;
					feat[2] = feature_2;
					feat[3] = feature_3;
					want = predict_winner(feat);
				end
				held_win <= want;
				expected_class.push_back(want);
			end
			pending <= expected_class.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int STRIDE = 21;
	localparam int LOADED = 16 * STRIDE;
	localparam longint CYCLE_LIMIT = 5000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic cfg_we = 1'b0;
	logic [4:0] cfg_data = '0;
	logic cmd = gcs_pkg::CMD_WRITE;
	logic gate = 1'b0;
	logic [8:0] model_addr = '0;
	logic signed [31:0] model_word = '0;
	logic signed [15:0] feature_0 = '0, feature_1 = '0, feature_2 = '0, feature_3 = '0;
	logic [3:0] winning_class;
	int pending, failures;
	longint cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	gaussian_class_scorer uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .cmd(cmd), .gate(gate),
		.model_addr(model_addr), .model_word(model_word),
		.feature_0(feature_0), .feature_1(feature_1), .feature_2(feature_2),
		.feature_3(feature_3), .winning_class(winning_class)
	);

	gcs_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .cmd(cmd), .gate(gate),
		.model_addr(model_addr), .model_word(model_word),
		.feature_0(feature_0), .feature_1(feature_1), .feature_2(feature_2),
		.feature_3(feature_3), .winning_class(winning_class),
		.pending(pending), .failures(failures)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("gaussian_class_scorer regression: fail");
			$finish;
		end
	end

	function automatic logic signed [31:0] span(input int r);
		return $signed($urandom_range(0, 2 * r)) - r;
	endfunction

	// plausible model word for its slot in a class block, sometimes raw noise
	function automatic logic signed [31:0] model_value(input int a);
		int slot, row, col;
		slot = a % STRIDE;
		if (a >= LOADED || $urandom_range(0, 99) < 10)
			return $urandom;
		if (slot < 4)
			return span(6 << 16);
		if (slot == STRIDE - 1)
			return ($urandom_range(0, 99) < 15) ? -span(1 << 20) : $urandom_range(1, 1 << 20);
		row = (slot - 4) / 4;
		col = (slot - 4) % 4;
		if (row == col)
			return $urandom_range(1 << 12, 2 << 16);
		return span(1 << 13);
	endfunction

	function automatic logic signed [15:0] feature_value();
		if ($urandom_range(0, 99) < 15)
			return 16'($urandom);
		return 16'(span(6 << 8));
	endfunction

	// start stays high on return so a following request can go straight on
	task automatic send(input logic c, input logic g, input int a,
			input logic signed [31:0] w, input logic signed [15:0] f0,
			input logic signed [15:0] f1, input logic signed [15:0] f2,
			input logic signed [15:0] f3);
		start <= 1'b1;
		cmd <= c;
		gate <= g;
		model_addr <= a[8:0];
		model_word <= w;
		feature_0 <= f0;
		feature_1 <= f1;
		feature_2 <= f2;
		feature_3 <= f3;
		do @(posedge clk); while (busy);
	endtask

	task automatic load(input int a);
		send(gcs_pkg::CMD_WRITE, 1'($urandom_range(0, 1)), a, model_value(a),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic sample(input logic g);
		send(gcs_pkg::CMD_SAMPLE, g, $urandom_range(0, 511), $urandom, feature_value(),
			feature_value(), feature_value(), feature_value());
	endtask

	// drain everything, then write the class count while idle
	task automatic set_classes(input logic [4:0] n);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int idle_pct, pick;
		logic [4:0] phase_classes [3];
		phase_classes = '{5'd16, 5'd1, 5'd31};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no classes scored: winner stays at zero
		set_classes(5'd0);
		send(gcs_pkg::CMD_SAMPLE, 1'b1, 0, 0, 16'sh7FFF, -16'sh8000, 16'sh0000, 16'shFFFF);
		send(gcs_pkg::CMD_SAMPLE, 1'b0, 511, 32'sh7FFFFFFF, 0, 0, 0, 0);

		// full model load, top of the store too
		for (int a = 0; a < LOADED; a++)
			load(a);
		send(gcs_pkg::CMD_WRITE, 1'b0, 511, -32'sh80000000, 0, 0, 0, 0);
		send(gcs_pkg::CMD_WRITE, 1'b1, 510, 32'sh7FFFFFFF, 0, 0, 0, 0);

		// one class with a negative weight never beats zero
		send(gcs_pkg::CMD_WRITE, 1'b0, STRIDE - 1, -32'sh10000, 0, 0, 0, 0);
		set_classes(5'd1);
		send(gcs_pkg::CMD_SAMPLE, 1'b1, 0, 0, 0, 0, 0, 0);
		send(gcs_pkg::CMD_WRITE, 1'b0, STRIDE - 1, 32'sh10000, 0, 0, 0, 0);

		// every class, feature extremes
		set_classes(5'd16);
		send(gcs_pkg::CMD_SAMPLE, 1'b1, 0, 0, 0, 0, 0, 0);
		send(gcs_pkg::CMD_SAMPLE, 1'b1, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send(gcs_pkg::CMD_SAMPLE, 1'b1, 0, 0, -16'sh8000, -16'sh8000, -16'sh8000,
			-16'sh8000);
		send(gcs_pkg::CMD_SAMPLE, 1'b0, 0, 0, 16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100);
		send(gcs_pkg::CMD_SAMPLE, 1'b1, 0, 0, 16'sh0080, -16'sh0080, 16'sh0200, -16'sh0300);

		// random phases: sender idling light, heavy, then none
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 15 : (ph == 1) ? 57 : 0;
			set_classes(phase_classes[ph]);
			for (int n = 0; n < 190; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					load($urandom_range(0, 511));
				else
					sample(pick >= 85 ? 1'b0 : 1'b1);
				if ($urandom_range(0, 99) < idle_pct) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
				// a mid-phase class count change, idle in between
				if (n == 95)
					set_classes(5'($urandom_range(0, 31)));
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("gaussian_class_scorer regression: pass");
		else
			$display("gaussian_class_scorer regression: fail");
		$finish;
	end

endmodule
